// ===== design/amdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdt_pkg
// Shared types and constants for the adjacency matrix degree tracker.
// ----------------------------------------------------------------------------
package amdt_pkg;

   // table size
   localparam int MAX_VERTICES = 16;
   localparam int VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DEG_W        = $clog2(MAX_VERTICES + 1);
   localparam int CNT_W        = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);

   // payload field widths
   localparam int CMD_W      = 1;
   localparam int VERTEX_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int OUT_DEG_W  = 5;
   localparam int IN_DEG_W   = 5;
   localparam int TOTAL_W    = 8;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int VCOUNT_W   = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTED_MODE = CSR_IDX_W'(1);

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = VCOUNT_W'(16);
   localparam logic                DIRECTED_RESET = 1'b1;

   // operation codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 1'b0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_CHANGED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE_ERR = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [OUT_DEG_W-1:0] from_out_degree;
      logic [IN_DEG_W-1:0]  to_in_degree;
      logic [TOTAL_W-1:0]   edge_total;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic sel_mirror;
      logic wr_fwd;
      logic wr_mir;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_err;
      logic changed;
      logic undirected;
   } ctrl_status_type;

endpackage

// ===== design/amdt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdt_ctrl
// Sequencer: read, update and optional mirror update of one request.
// ----------------------------------------------------------------------------
module amdt_ctrl
   import amdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type dp_status,
   output ctrl_cmd_type    dp_cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_FWD,
      S_WRITE_FWD,
      S_READ_MIR,
      S_WRITE_MIR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in            = state_ff;
      dp_cmd              = '0;
      dp_cmd.capture      = (state_ff == S_IDLE) && req_valid;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_READ_FWD;
            end
         end
         S_READ_FWD: begin
            state_in = dp_status.range_err ? S_DONE : S_WRITE_FWD;
         end
         S_WRITE_FWD: begin
            dp_cmd.wr_fwd = 1'b1;
            if (dp_status.changed && dp_status.undirected) begin
               state_in = S_READ_MIR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ_MIR: begin
            dp_cmd.sel_mirror = 1'b1;
            state_in          = S_WRITE_MIR;
         end
         S_WRITE_MIR: begin
            dp_cmd.wr_mir = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/amdt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amdt_datapath
// Adjacency rows, degree tables, edge count, settings and result register.
// ----------------------------------------------------------------------------
module amdt_datapath
   import amdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_payload_type       req_data,
   output rsp_payload_type       rsp_data,
   input  ctrl_cmd_type          dp_cmd,
   output ctrl_status_type       dp_status
);

   localparam logic [VERTEX_W-1:0]     MAX_V       = VERTEX_W'(MAX_VERTICES);
   localparam logic [MAX_VERTICES-1:0] ROW_ONE     = MAX_VERTICES'(1);
   localparam logic [VERTEX_W-1:0]     VERTEX_ONE  = VERTEX_W'(1);
   localparam logic [DEG_W-1:0]        DEG_ONE     = DEG_W'(1);
   localparam logic [CNT_W-1:0]        CNT_ONE     = CNT_W'(1);

   // settings
   logic [VCOUNT_W-1:0] vcount_ff, vcount_in;
   logic                directed_ff, directed_in;

   // captured request
   logic [CMD_W-1:0]  cmd_ff;
   logic [VIDX_W-1:0] f_ff;
   logic [VIDX_W-1:0] t_ff;
   logic              err_ff;

   // tables, one write and one read port each
   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [DEG_W-1:0]        out_mem [MAX_VERTICES];
   logic [DEG_W-1:0]        in_mem  [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_vld_ff, out_vld_ff, in_vld_ff;

   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic [DEG_W-1:0]        out_rd_ff, in_rd_ff;
   logic                    adj_rd_vld_ff, out_rd_vld_ff, in_rd_vld_ff;

   logic [CNT_W-1:0] count_ff, count_in;

   // result staging
   logic             changed_ff;
   logic [DEG_W-1:0] res_out_ff, res_in_ff;
   rsp_payload_type  rsp_data_ff;

   logic [VERTEX_W-1:0]     n_eff;
   logic [VERTEX_W-1:0]     vcount_ext;
   logic                    req_err;
   logic [VIDX_W-1:0]       row_addr, out_addr, in_addr, bit_idx;
   logic [MAX_VERTICES-1:0] adj_row;
   logic [DEG_W-1:0]        out_deg, in_deg, out_new, in_new;
   logic                    is_add, cur_bit, flip, wr_en;

   // write address: forward pass targets the first argument's pair
   function automatic logic [VIDX_W-1:0] row_addr_wr(input logic mir,
                                                     input logic [VIDX_W-1:0] a,
                                                     input logic [VIDX_W-1:0] b);
      return mir ? b : a;
   endfunction

   // range check on the incoming request
   assign vcount_ext = VERTEX_W'(vcount_ff);
   assign n_eff      = (vcount_ext > MAX_V) ? MAX_V : vcount_ext;
   assign req_err    = (req_data.from_vertex == '0) || (req_data.from_vertex > n_eff) ||
                       (req_data.to_vertex == '0) || (req_data.to_vertex > n_eff) ||
                       ((req_data.cmd == CMD_ADD) &&
                        (req_data.from_vertex == req_data.to_vertex));

   always_comb begin
      vcount_in   = vcount_ff;
      directed_in = directed_ff;
      if (csr_valid) begin
         if (csr_index == CSR_VERTEX_COUNT) begin
            vcount_in = csr_wdata[VCOUNT_W-1:0];
         end else if (csr_index == CSR_DIRECTED_MODE) begin
            directed_in = csr_wdata[0];
         end
      end
   end

   // forward pass uses row f, out f, in t; mirror pass swaps them
   assign row_addr = dp_cmd.sel_mirror ? t_ff : f_ff;
   assign out_addr = row_addr;
   assign in_addr  = dp_cmd.sel_mirror ? f_ff : t_ff;
   assign bit_idx  = dp_cmd.wr_mir ? f_ff : t_ff;

   assign adj_row = adj_rd_vld_ff ? adj_rd_ff : '0;
   assign out_deg = out_rd_vld_ff ? out_rd_ff : '0;
   assign in_deg  = in_rd_vld_ff  ? in_rd_ff  : '0;

   assign is_add  = (cmd_ff == CMD_ADD);
   assign cur_bit = adj_row[bit_idx];
   assign flip    = is_add ? !cur_bit : cur_bit;
   assign out_new = is_add ? (out_deg + DEG_ONE) : (out_deg - DEG_ONE);
   assign in_new  = is_add ? (in_deg + DEG_ONE) : (in_deg - DEG_ONE);
   assign wr_en   = (dp_cmd.wr_fwd || dp_cmd.wr_mir) && flip;

   always_comb begin
      count_in = count_ff;
      if (wr_en) begin
         count_in = is_add ? (count_ff + CNT_ONE) : (count_ff - CNT_ONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff   <= VCOUNT_RESET;
         directed_ff <= DIRECTED_RESET;
         count_ff    <= '0;
         adj_vld_ff  <= '0;
         out_vld_ff  <= '0;
         in_vld_ff   <= '0;
      end else begin
         vcount_ff   <= vcount_in;
         directed_ff <= directed_in;
         count_ff    <= count_in;
         if (wr_en) begin
            adj_vld_ff[row_addr_wr(dp_cmd.wr_mir, f_ff, t_ff)] <= 1'b1;
            out_vld_ff[row_addr_wr(dp_cmd.wr_mir, f_ff, t_ff)] <= 1'b1;
            in_vld_ff[row_addr_wr(dp_cmd.wr_mir, t_ff, f_ff)]  <= 1'b1;
         end
      end
   end

   // table storage and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[row_addr_wr(dp_cmd.wr_mir, f_ff, t_ff)] <= adj_row ^ (ROW_ONE << bit_idx);
         out_mem[row_addr_wr(dp_cmd.wr_mir, f_ff, t_ff)] <= out_new;
         in_mem[row_addr_wr(dp_cmd.wr_mir, t_ff, f_ff)]  <= in_new;
      end
      adj_rd_ff     <= adj_mem[row_addr];
      out_rd_ff     <= out_mem[out_addr];
      in_rd_ff      <= in_mem[in_addr];
      adj_rd_vld_ff <= adj_vld_ff[row_addr];
      out_rd_vld_ff <= out_vld_ff[out_addr];
      in_rd_vld_ff  <= in_vld_ff[in_addr];
   end

   // request capture and result staging
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff <= req_data.cmd;
         f_ff   <= VIDX_W'(req_data.from_vertex - VERTEX_ONE);
         t_ff   <= VIDX_W'(req_data.to_vertex - VERTEX_ONE);
         err_ff <= req_err;
      end
      if (dp_cmd.wr_fwd) begin
         changed_ff <= flip;
         res_out_ff <= flip ? out_new : out_deg;
         res_in_ff  <= flip ? in_new : in_deg;
      end
      if (dp_cmd.load_rsp) begin
         if (err_ff) begin
            rsp_data_ff.status          <= ST_RANGE_ERR;
            rsp_data_ff.from_out_degree <= '0;
            rsp_data_ff.to_in_degree    <= '0;
         end else begin
            rsp_data_ff.status          <= changed_ff ? ST_CHANGED : ST_NO_CHANGE;
            rsp_data_ff.from_out_degree <= OUT_DEG_W'(res_out_ff);
            rsp_data_ff.to_in_degree    <= IN_DEG_W'(res_in_ff);
         end
         rsp_data_ff.edge_total <= TOTAL_W'(count_ff);
      end
   end

   assign rsp_data             = rsp_data_ff;
   assign dp_status.range_err  = err_ff;
   assign dp_status.changed    = flip;
   assign dp_status.undirected = !directed_ff;

endmodule

// ===== design/adjacency_matrix_degree_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_degree_tracker_top
// Edge add/remove on an adjacency bit matrix with per-vertex degree counters.
// ----------------------------------------------------------------------------
// sequence: forward read and write states, then the mirror read and write
//   states when an undirected request changes its edge, then done; a range
//   error goes from the forward read straight to done, where the result waits
//   for a free output register. One request at a time; the next waits for done.
// reset: synchronous; clears the control, the edge count and the table valid
//   bits at once, so the graph starts empty with no clearing pass
module adjacency_matrix_degree_tracker_top
   import amdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type    dp_cmd;
   ctrl_status_type dp_status;

   assign csr_ready = 1'b1;

   amdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   amdt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // one request at a time: busy right after a transfer
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a previous one is in flight");

   // a range error reports no degrees
   a_err_zero_degrees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_RANGE_ERR) |->
      (rsp_data.from_out_degree == '0 && rsp_data.to_in_degree == '0))
      else $error("range error result carries degrees");

   // a new result only appears when the controller loads it
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(dp_cmd.load_rsp))
      else $error("result valid without a load");

   // status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_CHANGED || rsp_data.status == ST_NO_CHANGE ||
                     rsp_data.status == ST_RANGE_ERR))
      else $error("undefined status code");

endmodule

// ===== tb/sv/adjacency_matrix_degree_tracker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_degree_tracker_top_test
// Drives edge add/remove requests and vertex count / graph mode writes into
// the degree tracker. A scoreboard keeps its own adjacency matrix and degree
// counters, predicts every response in order, and compares it field by field.
// ----------------------------------------------------------------------------
module adjacency_matrix_degree_tracker_top_test;
   import amdt_pkg::*;

   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;

   // ------------------------------------------------------------------------
   // graph predictor and response checker
   // ------------------------------------------------------------------------
   class degree_scoreboard;
      logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
      int unsigned out_deg [MAX_VERTICES];
      int unsigned in_deg [MAX_VERTICES];
      int unsigned entries;
      int unsigned vertex_limit;
      bit directed;
      rsp_payload_type expected_q[$];
      int unsigned responses;
      int unsigned failures;

      function new();
         foreach (rows[i]) begin
            rows[i] = '0;
            out_deg[i] = 0;
            in_deg[i] = 0;
         end
         entries = 0;
         vertex_limit = VCOUNT_RESET;
         directed = DIRECTED_RESET;
         responses = 0;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_VERTEX_COUNT: vertex_limit = value[VCOUNT_W-1:0];
            CSR_DIRECTED_MODE: directed = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned usable_count();
         return (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
      endfunction

      function void add_entry(int unsigned f, int unsigned t);
         rows[f][t] = 1'b1;
         out_deg[f]++;
         in_deg[t]++;
         entries++;
      endfunction

      function void drop_entry(int unsigned f, int unsigned t);
         rows[f][t] = 1'b0;
         out_deg[f]--;
         in_deg[t]--;
         entries--;
      endfunction

      function void note_request(req_payload_type r);
         int unsigned n;
         int unsigned f;
         int unsigned t;
         rsp_payload_type e;
         n = usable_count();
         if (r.from_vertex == 0 || r.from_vertex > n || r.to_vertex == 0 || r.to_vertex > n
             || (r.cmd == CMD_ADD && r.from_vertex == r.to_vertex)) begin
            e.status = ST_RANGE_ERR;
            e.from_out_degree = '0;
            e.to_in_degree = '0;
         end else begin
            f = r.from_vertex - 1;
            t = r.to_vertex - 1;
            // the primary edge alone decides the status, the mirror follows its own bit
            if (r.cmd == CMD_ADD) begin
               if (rows[f][t]) begin
                  e.status = ST_NO_CHANGE;
               end else begin
                  add_entry(f, t);
                  if (!directed && !rows[t][f]) add_entry(t, f);
                  e.status = ST_CHANGED;
               end
            end else begin
               if (!rows[f][t]) begin
                  e.status = ST_NO_CHANGE;
               end else begin
                  drop_entry(f, t);
                  if (!directed && rows[t][f]) drop_entry(t, f);
                  e.status = ST_CHANGED;
               end
            end
            e.from_out_degree = OUT_DEG_W'(out_deg[f]);
            e.to_in_degree = IN_DEG_W'(in_deg[t]);
         end
         e.edge_total = TOTAL_W'(entries);
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type e;
         responses++;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response %0d: status %0d out %0d in %0d total %0d",
                        responses, got.status, got.from_out_degree, got.to_in_degree,
                        got.edge_total);
         end else begin
            e = expected_q.pop_front();
            if (got.status !== e.status || got.from_out_degree !== e.from_out_degree
                || got.to_in_degree !== e.to_in_degree || got.edge_total !== e.edge_total) begin
               failures++;
               if (failures <= 10) begin
                  $write("mismatch on response %0d: expected status %0d out %0d in %0d ",
                         responses, e.status, e.from_out_degree, e.to_in_degree);
                  $display("total %0d, got status %0d out %0d in %0d total %0d",
                           e.edge_total, got.status, got.from_out_degree, got.to_in_degree,
                           got.edge_total);
               end
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block and stimulus signals
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   degree_scoreboard sb = new();
   int unsigned items_sent = 0;
   bit calm = 1'b0;
   bit long_hold = 1'b0;

   adjacency_matrix_degree_tracker_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // both transfer monitors sample at the edge, before the block updates
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // response side back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
         end
      end
   end

   task automatic send_request(input req_payload_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_item(input logic [CMD_W-1:0] cmd, input int from_v, input int to_v);
      req_payload_type p;
      p.cmd = cmd;
      p.from_vertex = VERTEX_W'(from_v);
      p.to_vertex = VERTEX_W'(to_v);
      send_request(p);
   endtask

   // waits for every response, then lets the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.responses < items_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes both registers; unused upper data bits carry noise
   task automatic configure(input int vc, input bit mode);
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'($urandom);
      d[VCOUNT_W-1:0] = VCOUNT_W'(vc);
      csr_valid <= 1'b1;
      csr_index <= CSR_VERTEX_COUNT;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(CSR_VERTEX_COUNT, d);
      d = CSR_DATA_W'($urandom);
      d[0] = mode;
      csr_index <= CSR_DIRECTED_MODE;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(CSR_DIRECTED_MODE, d);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int vc, input bit mode, input int count,
                                   input bit quiet, input bit squeeze);
      int n;
      req_payload_type p;
      configure(vc, mode);
      calm = quiet;
      if (squeeze) long_hold = 1'b1;
      n = sb.usable_count();
      repeat (count) begin
         p.cmd = ($urandom_range(0, 99) < 55) ? CMD_ADD : CMD_REMOVE;
         // mostly ids in range, a few arbitrary ones
         p.from_vertex = (n > 0 && $urandom_range(0, 99) < 90) ?
                         VERTEX_W'($urandom_range(1, n)) : VERTEX_W'($urandom_range(0, 255));
         p.to_vertex = (n > 0 && $urandom_range(0, 99) < 90) ?
                       VERTEX_W'($urandom_range(1, n)) : VERTEX_W'($urandom_range(0, 255));
         send_request(p);
      end
      wait_idle();
      calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed graph, full size
      configure(16, 1'b1);
      send_item(CMD_ADD, 1, 2);
      send_item(CMD_ADD, 1, 2);
      send_item(CMD_ADD, 2, 1);
      send_item(CMD_REMOVE, 1, 2);
      send_item(CMD_REMOVE, 1, 2);
      send_item(CMD_ADD, 3, 3);
      send_item(CMD_REMOVE, 3, 3);
      send_item(CMD_ADD, 0, 5);
      send_item(CMD_ADD, 5, 0);
      send_item(CMD_ADD, 16, 1);
      send_item(CMD_ADD, 1, 16);
      send_item(CMD_ADD, 17, 1);
      send_item(CMD_REMOVE, 1, 17);
      send_item(CMD_ADD, 255, 255);
      send_item(CMD_REMOVE, 0, 0);
      send_item(CMD_ADD, 16, 15);
      wait_idle();

      // switch to undirected with one-way edges already stored
      configure(16, 1'b0);
      send_item(CMD_REMOVE, 2, 1);
      send_item(CMD_ADD, 4, 5);
      send_item(CMD_ADD, 5, 4);
      send_item(CMD_REMOVE, 5, 4);
      send_item(CMD_ADD, 1, 16);
      wait_idle();

      // lowered count hides vertex 16 but keeps its edges
      configure(8, 1'b0);
      send_item(CMD_REMOVE, 16, 1);
      send_item(CMD_ADD, 8, 1);
      wait_idle();

      // no vertices at all
      configure(0, 1'b1);
      send_item(CMD_ADD, 1, 2);
      send_item(CMD_REMOVE, 1, 1);
      wait_idle();

      // count above the table size acts as full size
      configure(31, 1'b1);
      send_item(CMD_REMOVE, 16, 1);
      wait_idle();

      run_random_phase(16, 1'b0, 220, 1'b0, 1'b0);
      run_random_phase(4, 1'b1, 140, 1'b0, 1'b0);
      run_random_phase(16, 1'b1, 200, 1'b0, 1'b1);
      run_random_phase(1, 1'b0, 40, 1'b0, 1'b0);
      run_random_phase(2, 1'b0, 80, 1'b0, 1'b0);
      run_random_phase(20, 1'b0, 160, 1'b0, 1'b0);
      run_random_phase(5, 1'b1, 120, 1'b1, 1'b0);
      run_random_phase(3, 1'b0, 80, 1'b0, 1'b0);
      repeat (3) run_random_phase($urandom_range(0, 31), 1'($urandom), 60, 1'b0, 1'b0);

      if (sb.failures == 0 && sb.expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== adjacency_matrix_degree_tracker_top.f =====
design/amdt_pkg.sv
design/amdt_ctrl.sv
design/amdt_datapath.sv
design/adjacency_matrix_degree_tracker_top.sv
tb/sv/adjacency_matrix_degree_tracker_top_test.sv
